// ----- hdl/chtc_pkg.sv -----
`timescale 1ns / 1ps
// shared constants and codes of the chained hash count table
// no dependencies

package chtc_pkg;

    localparam int KEY_W = 32;
    localparam int CNT_W = 32;

    localparam int DEF_BUCKETS        = 1024;
    localparam int DEF_OVERFLOW_SLOTS = 1024;

    // bits of the key folded into the bucket remainder per cycle
    localparam int HASH_DIGIT_W = 4;
    localparam int HASH_STEPS   = KEY_W / HASH_DIGIT_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

// ----- hdl/chtc_if.sv -----
`timescale 1ns / 1ps
// request and response channel interfaces with valid/ready handshake
// depends on chtc_pkg

interface chtc_req_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic signed [chtc_pkg::KEY_W-1:0] key_value;

    modport source (output valid, output req_type, output key_value, input ready);
    modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface chtc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [chtc_pkg::CNT_W-1:0] count_out;
    logic                       status;

    modport source (output valid, output count_out, output status, input ready);
    modport sink   (input valid, input count_out, input status, output ready);
endinterface

// ----- hdl/chained_hash_count_table.sv -----
`timescale 1ns / 1ps
// chained hash count table top level: request sequencer, bucket and entry rams
// depends on chtc_pkg, chtc_if, chtc_ram, chtc_hash
//
// usage
//   i_req carries one request per transaction: req_type 0 counts one more
//   occurrence of key_value, req_type 1 asks for its count. o_rsp returns one
//   transaction per request with the count (0 if absent) and a status that
//   flags an insert dropped because the overflow pool is full.
//   requests are served one at a time. after acceptance the bucket
//   index is computed, from the low key bits for a power-of-two bucket
//   count and by the digit-serial modulo unit otherwise; then the chain
//   entries are read, one per cycle through the single read port of the
//   entry ram, and appending a new overflow entry takes a second write,
//   before the result is loaded into the output register. i_req.ready is
//   high only while idle, so a new request is accepted only after the
//   previous result has been loaded into the output register.
//   the next request may be accepted while a result waits in the output
//   register; a stalled o_rsp holds its transaction and the block stops
//   before loading the following result.
//   after reset the bucket-used ram is cleared, one bucket per cycle;
//   no request is accepted until every bucket has been cleared.

module chained_hash_count_table #(
    parameter int BUCKETS        = chtc_pkg::DEF_BUCKETS,
    parameter int OVERFLOW_SLOTS = chtc_pkg::DEF_OVERFLOW_SLOTS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    chtc_req_if.sink   i_req,
    chtc_rsp_if.source o_rsp
);

    localparam int TOTAL = BUCKETS + OVERFLOW_SLOTS;
    localparam int BW    = $clog2(BUCKETS);
    localparam int IW    = $clog2(TOTAL);
    localparam int LW    = $clog2(TOTAL + 1);
    localparam int FW    = $clog2(OVERFLOW_SLOTS + 1);
    localparam int KW    = chtc_pkg::KEY_W;
    localparam int CW    = chtc_pkg::CNT_W;
    localparam int EW    = KW + CW + LW;

    localparam logic [LW-1:0] LINK_NONE = '1;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH   = 3'd2;
    localparam logic [2:0] S_HEAD   = 3'd3;
    localparam logic [2:0] S_CHK    = 3'd4;
    localparam logic [2:0] S_APPEND = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [BW-1:0] r_clr, n_clr;
    logic [FW-1:0] r_free, n_free;
    logic          r_out_valid, n_out_valid;

    logic          r_type;
    logic [KW-1:0] r_key;
    logic [BW-1:0] r_bucket, n_bucket;
    logic [IW-1:0] r_at, n_at;
    logic [CW-1:0] r_count, n_count;
    logic          r_status, n_status;
    logic [CW-1:0] r_out_count;
    logic          r_out_status;

    logic          accept;
    logic          load_out;
    logic          hash_done;
    logic [BW-1:0] hash_bucket;

    logic          used_we, used_re, used_wdata, used_rdata;
    logic [BW-1:0] used_waddr, used_raddr;

    logic          ent_we, ent_re;
    logic [IW-1:0] ent_waddr, ent_raddr;
    logic [EW-1:0] ent_wdata, ent_rdata;

    logic [KW-1:0] e_key;
    logic [CW-1:0] e_cnt;
    logic [LW-1:0] e_link;
    logic [IW-1:0] slot;
    logic          chk;

    assign accept   = i_req.valid && i_req.ready;
    assign load_out = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);
    assign e_key    = ent_rdata[EW-1 -: KW];
    assign e_cnt    = ent_rdata[LW +: CW];
    assign e_link   = ent_rdata[LW-1:0];
    assign slot     = IW'(BUCKETS) + IW'(r_free);
    assign chk      = (r_state == S_CHK) || ((r_state == S_HEAD) && used_rdata);

    chtc_hash #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_key    (i_req.key_value),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    chtc_ram #(
        .DEPTH (BUCKETS),
        .WIDTH (1),
        .AW    (BW)
    ) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (used_wdata),
        .i_re    (used_re),
        .i_raddr (used_raddr),
        .o_rdata (used_rdata)
    );

    chtc_ram #(
        .DEPTH (TOTAL),
        .WIDTH (EW),
        .AW    (IW)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_free      = r_free;
        n_bucket    = r_bucket;
        n_at        = r_at;
        n_count     = r_count;
        n_status    = r_status;
        n_out_valid = r_out_valid;

        used_we    = 1'b0;
        used_waddr = r_bucket;
        used_wdata = 1'b0;
        used_re    = 1'b0;
        used_raddr = hash_bucket;
        ent_we     = 1'b0;
        ent_waddr  = r_at;
        ent_wdata  = {r_key, CW'(1), LINK_NONE};
        ent_re     = 1'b0;
        ent_raddr  = IW'(hash_bucket);

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
        end

        case (r_state)
            S_CLEAR: begin
                used_we    = 1'b1;
                used_waddr = r_clr;
                n_clr      = r_clr + 1'b1;
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    used_re  = 1'b1;
                    ent_re   = 1'b1;
                    n_bucket = hash_bucket;
                    n_at     = IW'(hash_bucket);
                    n_state  = S_HEAD;
                end
            end
            S_HEAD, S_CHK: begin
                n_status = chtc_pkg::STATUS_OK;
                if (!chk) begin
                    // empty bucket: on an insert the key becomes its head entry
                    n_count = '0;
                    if (r_type == chtc_pkg::REQ_INSERT) begin
                        used_we    = 1'b1;
                        used_wdata = 1'b1;
                        ent_we     = 1'b1;
                        n_count    = CW'(1);
                    end
                    n_state = S_DONE;
                end else if (e_key == r_key) begin
                    n_count = e_cnt;
                    if (r_type == chtc_pkg::REQ_INSERT && e_cnt != chtc_pkg::COUNT_MAX) begin
                        ent_we    = 1'b1;
                        ent_wdata = {e_key, e_cnt + 1'b1, e_link};
                        n_count   = e_cnt + 1'b1;
                    end
                    n_state = S_DONE;
                end else if (e_link != LINK_NONE) begin
                    ent_re    = 1'b1;
                    ent_raddr = e_link[IW-1:0];
                    n_at      = e_link[IW-1:0];
                    n_state   = S_CHK;
                end else begin
                    n_count = '0;
                    n_state = S_DONE;
                    if (r_type == chtc_pkg::REQ_INSERT) begin
                        if (r_free == FW'(OVERFLOW_SLOTS)) begin
                            n_status = chtc_pkg::STATUS_FULL;
                        end else begin
                            // link the tail to the next free overflow slot
                            ent_we    = 1'b1;
                            ent_wdata = {e_key, e_cnt, LW'(slot)};
                            n_state   = S_APPEND;
                        end
                    end
                end
            end
            S_APPEND: begin
                ent_we    = 1'b1;
                ent_waddr = slot;
                n_free    = r_free + 1'b1;
                n_count   = CW'(1);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type <= i_req.req_type;
            r_key  <= i_req.key_value;
        end
        r_bucket <= n_bucket;
        r_at     <= n_at;
        r_count  <= n_count;
        r_status <= n_status;
        if (load_out) begin
            r_out_count  <= r_count;
            r_out_status <= r_status;
        end
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.count_out = r_out_count;
    assign o_rsp.status    = r_out_status;

endmodule

// ----- hdl/chtc_ram.sv -----
`timescale 1ns / 1ps
// single-port-write, single-port-read synchronous ram, registered read data
// no dependencies

module chtc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/chtc_hash.sv -----
`timescale 1ns / 1ps
// bucket index unit: key modulo bucket count, adding the stored residue of one key digit per cycle
// power-of-two bucket counts take the low key bits directly; depends on chtc_pkg

module chtc_hash #(
    parameter int BUCKETS = chtc_pkg::DEF_BUCKETS,
    parameter int BW      = $clog2(BUCKETS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [chtc_pkg::KEY_W-1:0] i_key,
    output logic                       o_done,
    output logic [BW-1:0]              o_bucket
);

    localparam bit          IS_POW2 = (BUCKETS == (1 << BW));
    localparam int          SCW     = $clog2(chtc_pkg::HASH_STEPS);
    localparam int          DIGITS  = 1 << chtc_pkg::HASH_DIGIT_W;
    localparam logic [BW:0] BK      = (BW + 1)'(BUCKETS);

    logic                       r_busy;
    logic                       r_done;
    logic [SCW-1:0]             r_step;
    logic [chtc_pkg::KEY_W-1:0] r_sh;
    logic [BW-1:0]              r_rem;
    logic [BW-1:0]              n_rem;
    logic [BW-1:0]              w_res [chtc_pkg::HASH_STEPS][DIGITS];

    // residue of each digit value at each digit position
    for (genvar p = 0; p < chtc_pkg::HASH_STEPS; p++) begin : g_pos
        for (genvar d = 0; d < DIGITS; d++) begin : g_digit
            assign w_res[p][d] = BW'((64'(d) << (chtc_pkg::HASH_DIGIT_W * p)) % BUCKETS);
        end
    end

    always_comb begin
        logic [BW:0] t;
        t = {1'b0, r_rem} + {1'b0, w_res[r_step][r_sh[chtc_pkg::HASH_DIGIT_W-1:0]]};
        if (t >= BK) begin
            t = t - BK;
        end
        n_rem = t[BW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_step <= '0;
                if (IS_POW2) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == SCW'(chtc_pkg::HASH_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh <= i_key;
            if (IS_POW2) begin
                r_rem <= i_key[BW-1:0];
            end else begin
                r_rem <= '0;
            end
        end else if (r_busy) begin
            r_sh  <= r_sh >> chtc_pkg::HASH_DIGIT_W;
            r_rem <= n_rem;
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem;

endmodule
